// File: rtl/dfr_pkg.sv
// Shared constants and types for the checksummed frame deframer.
package dfr_pkg;

  // Frame format bytes.
  localparam logic [7:0] START_BYTE = 8'hA5;
  localparam logic [7:0] END_BYTE   = 8'h0D;

  // Payload sizing.
  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = IDX_W + 1;

  // Payload store: two banks so one frame can replay while the next arrives.
  localparam int NUM_BANKS  = 2;
  localparam int STORE_DEPTH = NUM_BANKS * MAX_PAYLOAD;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Depth of the frame queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Largest payload length ever accepted, at the configuration width.
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // One validated frame waiting for replay.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } frame_desc_t;

  // Bank handed back by the replay side once its last byte is read.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

// File: rtl/dfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/dfr_front.sv
// Front part: parses the byte stream, checks frames and fills the payload banks.
module dfr_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic [dfr_pkg::LEN_W-1:0] max_len,
  input  dfr_pkg::bank_rel_t        rel,
  input  logic                      q_full,
  output logic                      push_valid,
  output dfr_pkg::frame_desc_t      push_desc,
  output logic                      wr_en,
  output logic [dfr_pkg::STORE_AW-1:0] wr_addr,
  output logic [7:0]                wr_data
);
  import dfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_CK_LO,
    PH_CK_HI,
    PH_END
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [LEN_W-1:0]       cnt_r, cnt_nxt;
  logic [15:0]            sum_r, sum_nxt;
  logic [15:0]            ck_r, ck_nxt;
  logic                   wr_bank_r, wr_bank_nxt;
  logic [NUM_BANKS-1:0]   busy_r, busy_nxt;

  logic                   accept;
  logic [15:0]            full_len;
  logic [LEN_W-1:0]       limit;
  logic [LEN_W-1:0]       cnt_inc;

  // The effective limit never exceeds the store size.
  assign limit    = (max_len > MAX_LEN) ? MAX_LEN : max_len;
  assign full_len = {in_rx_byte, len_lo_r};
  assign cnt_inc  = cnt_r + LEN_W'(1);

  // Hold off a data byte while its bank is still replaying, and the end byte
  // while the queue has no room.
  always_comb begin
    unique case (phase_r)
      PH_DATA: in_ready = !busy_r[wr_bank_r];
      PH_END:  in_ready = !q_full;
      default: in_ready = 1'b1;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Parser next-state logic.
  always_comb begin
    phase_nxt   = phase_r;
    len_lo_nxt  = len_lo_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    ck_nxt      = ck_r;
    wr_bank_nxt = wr_bank_r;
    busy_nxt    = busy_r;
    push_valid  = 1'b0;
    push_desc   = '{bank: wr_bank_r, len: len_r};
    wr_en       = 1'b0;
    wr_addr     = {wr_bank_r, cnt_r[IDX_W-1:0]};
    wr_data     = in_rx_byte;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      unique case (phase_r)
        PH_LEN_LO: begin
          len_lo_nxt = in_rx_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          cnt_nxt = '0;
          sum_nxt = '0;
          len_nxt = full_len[LEN_W-1:0];
          if (full_len > 16'(limit)) begin
            phase_nxt = PH_HUNT;
          end else if (full_len == 16'd0) begin
            phase_nxt = PH_CK_LO;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en   = 1'b1;
          sum_nxt = sum_r + 16'(in_rx_byte);
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CK_LO;
          end
        end
        PH_CK_LO: begin
          ck_nxt    = {8'd0, in_rx_byte};
          phase_nxt = PH_CK_HI;
        end
        PH_CK_HI: begin
          ck_nxt    = {in_rx_byte, ck_r[7:0]};
          phase_nxt = PH_END;
        end
        PH_END: begin
          if (in_rx_byte == END_BYTE && sum_r == ck_r) begin
            push_valid = 1'b1;
            // An empty frame never touches the store, so its bank stays ours.
            if (len_r != '0) begin
              busy_nxt[wr_bank_r] = 1'b1;
              wr_bank_nxt         = !wr_bank_r;
            end
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = (in_rx_byte == START_BYTE) ? PH_LEN_LO : PH_HUNT;
        end
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      wr_bank_r <= 1'b0;
      busy_r    <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      ck_r      <= '0;
    end else begin
      phase_r   <= phase_nxt;
      wr_bank_r <= wr_bank_nxt;
      busy_r    <= busy_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      ck_r      <= ck_nxt;
    end
    len_lo_r <= len_lo_nxt;
  end

  // A payload byte must never land in a bank that is still being replayed.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !busy_r[wr_bank_r])
    else $error("payload write into a busy bank");

  // A frame is only queued when the queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_full)
    else $error("frame pushed into a full queue");

endmodule

// File: rtl/dfr_queue.sv
// Small queue of validated frames between the front and back parts.
module dfr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dfr_pkg::frame_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output dfr_pkg::frame_desc_t head_desc
);
  import dfr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  frame_desc_t     slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   count_r;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = slot_r[rptr_r];

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_desc;
    end
  end

  // The fill count stays within the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("frame queue count out of range");

endmodule

// File: rtl/dfr_back.sv
// Back part: replays queued frames from the payload store as result requests.
module dfr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  dfr_pkg::frame_desc_t         q_desc,
  output logic                         q_pop,
  output logic                         rd_en,
  output logic [dfr_pkg::STORE_AW-1:0] rd_addr,
  input  logic [7:0]                   rd_data,
  output dfr_pkg::bank_rel_t           rel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_payload_byte,
  output logic [dfr_pkg::IDX_W-1:0]    out_byte_index,
  output logic [dfr_pkg::LEN_W-1:0]    out_frame_length,
  output logic                         out_has_byte,
  output logic                         out_last
);
  import dfr_pkg::*;

  logic              act_r, act_nxt;
  logic              bank_r, bank_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;

  logic              ov_r, ov_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic [IDX_W-1:0]  oi_r, oi_nxt;
  logic [LEN_W-1:0]  ol_r, ol_nxt;
  logic              oh_r, oh_nxt;
  logic              olast_r, olast_nxt;

  logic              out_free;
  logic              pend_last;

  assign out_free  = !ov_r || out_ready;
  assign pend_last = (({1'b0, pidx_r} + LEN_W'(1)) == len_r);

  // Replay sequencing: one store read in flight, then into the output register.
  always_comb begin
    act_nxt   = act_r;
    bank_nxt  = bank_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    ov_nxt    = ov_r && !out_ready;
    ob_nxt    = ob_r;
    oi_nxt    = oi_r;
    ol_nxt    = ol_r;
    oh_nxt    = oh_r;
    olast_nxt = olast_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {bank_r, idx_r[IDX_W-1:0]};
    rel       = '{valid: 1'b0, bank: bank_r};

    if (pend_r) begin
      // Read data is back; the output register is free by construction.
      ov_nxt    = 1'b1;
      ob_nxt    = rd_data;
      oi_nxt    = pidx_r;
      ol_nxt    = len_r;
      oh_nxt    = 1'b1;
      olast_nxt = pend_last;
      if (pend_last) begin
        act_nxt   = 1'b0;
        rel.valid = 1'b1;
      end
    end else if (act_r) begin
      if (out_free && idx_r < len_r) begin
        rd_en    = 1'b1;
        pend_nxt = 1'b1;
        pidx_nxt = idx_r[IDX_W-1:0];
        idx_nxt  = idx_r + LEN_W'(1);
      end
    end else if (q_valid && out_free) begin
      q_pop = 1'b1;
      if (q_desc.len == '0) begin
        // Empty frame: one result with no byte.
        ov_nxt    = 1'b1;
        ob_nxt    = '0;
        oi_nxt    = '0;
        ol_nxt    = '0;
        oh_nxt    = 1'b0;
        olast_nxt = 1'b1;
      end else begin
        act_nxt  = 1'b1;
        bank_nxt = q_desc.bank;
        len_nxt  = q_desc.len;
        idx_nxt  = '0;
      end
    end
  end

  // Replay and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
    bank_r  <= bank_nxt;
    len_r   <= len_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    ob_r    <= ob_nxt;
    oi_r    <= oi_nxt;
    ol_r    <= ol_nxt;
    oh_r    <= oh_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_payload_byte = ob_r;
  assign out_byte_index   = oi_r;
  assign out_frame_length = ol_r;
  assign out_has_byte     = oh_r;
  assign out_last         = olast_r;

  // A read is only issued when its data can move straight into the output.
  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !ov_r)
    else $error("store read returned into an occupied output register");

  // A new frame is only taken once the previous one is fully replayed.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!act_r && !pend_r))
    else $error("frame popped during a replay");

endmodule

// File: rtl/checksummed_frame_deframer.sv
// Top level of the checksummed frame deframer.
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one link byte per request.
// Frames are 0xA5, a little-endian 16-bit length, the payload, a little-endian
// 16-bit additive checksum and 0x0D. Bad or oversized frames are dropped.
// Output channel (out_valid/out_ready/out_*) gives one request per payload
// byte of each good frame, or a single byte-less request for an empty frame.
// cfg_wr_en/cfg_wr_data write the largest accepted payload length (reset 64).
// The parser takes one byte per cycle while in_ready is high. Replay keeps
// one store read in flight; its read data goes to the output register
// before the next read. The first result follows the end byte through the
// queue, replay start, store read and output register. Two payload banks and a
// two-entry frame queue let the next frame arrive during a replay; in_ready
// drops only when the next frame's bank is still replaying or the queue is
// full. A stalled receiver just holds the output register and backs up
// through the queue. Reset returns the parser to hunting, empties the queue
// and frees both banks; no clearing pass is needed.
module checksummed_frame_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_payload_byte,
  output logic [dfr_pkg::IDX_W-1:0] out_byte_index,
  output logic [dfr_pkg::LEN_W-1:0] out_frame_length,
  output logic                      out_has_byte,
  output logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [dfr_pkg::LEN_W-1:0] cfg_wr_data
);
  import dfr_pkg::*;

  logic [LEN_W-1:0]    max_len_r;
  bank_rel_t           rel;
  logic                q_full;
  logic                push_valid;
  frame_desc_t         push_desc;
  logic                q_pop;
  logic                q_valid;
  frame_desc_t         q_desc;
  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]          rd_data;

  // Length limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  dfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .max_len    (max_len_r),
    .rel        (rel),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  dfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (q_desc)
  );

  dfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_desc           (q_desc),
    .q_pop            (q_pop),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .rel              (rel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_has_byte     (out_has_byte),
    .out_last         (out_last)
  );

endmodule
